// ===== rtl/mmsr_pkg.sv =====
// shared types and constants of the streamed matrix multiply
package mmsr_pkg;

  localparam int unsigned CFG_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned DOT_W = 38;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_ROWS  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_WEIGHT = 1'b0,
    ACT_STREAM = 1'b1
  } action_e;

  // control that travels with each pair of operands
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic             row_done;
    logic             matrix_done;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } tag_t;

endpackage

// ===== rtl/mmsr_mac.sv =====
// multiply and accumulate stage with the result output register
module mmsr_mac #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [DATA_BITS-1:0]             a_i,
  input  logic signed [DATA_BITS-1:0]             b_i,
  input  mmsr_pkg::tag_t                          tag_i,
  output logic                                    adv_o,
  output logic                                    busy_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [mmsr_pkg::DOT_W-1:0]       dot_value_o,
  output logic        [mmsr_pkg::POS_W-1:0]       result_row_o,
  output logic        [mmsr_pkg::POS_W-1:0]       result_col_o,
  output logic                                    row_done_o,
  output logic                                    matrix_done_o
);

  localparam int unsigned PROD_W = 2 * DATA_BITS;
  localparam int unsigned EXT_W = (PROD_W > mmsr_pkg::DOT_W) ? PROD_W : mmsr_pkg::DOT_W;

  mmsr_pkg::tag_t                     tag_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic signed [EXT_W-1:0]            prod_ext;
  logic signed [mmsr_pkg::DOT_W-1:0]  acc_q;
  logic signed [mmsr_pkg::DOT_W-1:0]  sum;
  logic                               out_valid_q;
  logic                               adv;
  logic                               load;

  // a finished column waits here only if the output word is still unread
  assign adv = !(tag_q.vld && tag_q.last && out_valid_q && !out_ready_i);
  assign load = adv && tag_q.vld && tag_q.last;

  assign prod_ext = EXT_W'(prod_q);
  assign sum = (tag_q.first ? '0 : acc_q) + mmsr_pkg::DOT_W'(prod_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        tag_q <= tag_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= a_i * b_i;
      if (tag_q.vld) begin
        acc_q <= sum;
      end
    end
    if (load) begin
      dot_value_o <= sum;
      result_row_o <= tag_q.row;
      result_col_o <= tag_q.col;
      row_done_o <= tag_q.row_done;
      matrix_done_o <= tag_q.matrix_done;
    end
  end

  assign adv_o = adv;
  assign busy_o = tag_q.vld;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/matrix_multiply_streamed_rows.sv =====
// streamed matrix multiply: weight store, row buffer, column sequencer
// an item that writes a weight or does not end an A row leaves the block ready for the next item
// the item that ends a row starts inner_size*out_cols reads through one MAC unit,
// one per cycle while no unread result stalls the MAC; no new item is taken
// until the pipeline has drained, and out_valid_o marks each finished dot product;
// reset sets the size registers to 1, positions to 0
module matrix_multiply_streamed_rows #(
  parameter int unsigned MAX_DIM   = 64,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mmsr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mmsr_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic [mmsr_pkg::POS_W-1:0]            weight_row_i,
  input  logic [mmsr_pkg::POS_W-1:0]            weight_col_i,
  input  logic signed [DATA_BITS-1:0]           element_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mmsr_pkg::DOT_W-1:0]     dot_value_o,
  output logic [mmsr_pkg::POS_W-1:0]            result_row_o,
  output logic [mmsr_pkg::POS_W-1:0]            result_col_o,
  output logic                                  row_done_o,
  output logic                                  matrix_done_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIM);
  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned IN_IDX_N = 2 ** mmsr_pkg::POS_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [mmsr_pkg::CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  logic [mmsr_pkg::CFG_W-1:0] inner_q, cols_q, rows_q;
  logic [CNT_W-1:0]           k_lim, n_lim, m_lim;

  state_e           state_q;
  logic [IDX_W-1:0] col_pos_q, row_pos_q;
  logic [IDX_W-1:0] kk_q, j_q;
  logic [IDX_W-1:0] run_row_q;
  logic             run_last_q;
  mmsr_pkg::tag_t   tag1_q;

  logic [DATA_BITS-1:0] w_mem [MAX_DIM][MAX_DIM];
  logic [DATA_BITS-1:0] row_mem [MAX_DIM];
  logic [DATA_BITS-1:0] a_q, b_q;

  logic [IDX_W-1:0] mod_tab [IN_IDX_N];
  logic [IDX_W-1:0] w_row, w_col;

  logic accept, acc_weight, acc_stream, row_end, last_row;
  logic kk_last, j_last;
  logic adv, mac_busy;

  for (genvar g = 0; g < IN_IDX_N; g++) begin : g_mod
    assign mod_tab[g] = IDX_W'(g % MAX_DIM);
  end

  assign w_row = mod_tab[weight_row_i];
  assign w_col = mod_tab[weight_col_i];

  assign k_lim = clamp_dim(inner_q);
  assign n_lim = clamp_dim(cols_q);
  assign m_lim = clamp_dim(rows_q);

  // new words wait until the pipeline has drained the row buffer reads
  assign in_ready_o = (state_q == ST_IDLE) && !tag1_q.vld && !mac_busy;
  assign accept = in_valid_i && in_ready_o;
  assign acc_weight = accept && (action_i == mmsr_pkg::ACT_WEIGHT);
  assign acc_stream = accept && (action_i == mmsr_pkg::ACT_STREAM);
  assign row_end = (CNT_W'(col_pos_q) + CNT_W'(1)) >= k_lim;
  assign last_row = (CNT_W'(row_pos_q) + CNT_W'(1)) >= m_lim;

  assign kk_last = (CNT_W'(kk_q) + CNT_W'(1)) == k_lim;
  assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == n_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= mmsr_pkg::CFG_W'(1);
      cols_q <= mmsr_pkg::CFG_W'(1);
      rows_q <= mmsr_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmsr_pkg::CFG_INNER: inner_q <= cfg_data_i;
        mmsr_pkg::CFG_COLS:  cols_q <= cfg_data_i;
        mmsr_pkg::CFG_ROWS:  rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_pos_q <= '0;
      row_pos_q <= '0;
      kk_q <= '0;
      j_q <= '0;
      run_row_q <= '0;
      run_last_q <= 1'b0;
      tag1_q <= '0;
    end else begin
      if (acc_stream) begin
        if (row_end) begin
          col_pos_q <= '0;
          row_pos_q <= last_row ? '0 : row_pos_q + IDX_W'(1);
          run_row_q <= row_pos_q;
          run_last_q <= last_row;
          kk_q <= '0;
          j_q <= '0;
          state_q <= ST_RUN;
        end else begin
          col_pos_q <= col_pos_q + IDX_W'(1);
        end
      end
      if (adv) begin
        tag1_q.vld <= (state_q == ST_RUN);
        tag1_q.first <= (kk_q == '0);
        tag1_q.last <= kk_last;
        tag1_q.row_done <= j_last;
        tag1_q.matrix_done <= j_last && run_last_q;
        tag1_q.col <= mmsr_pkg::POS_W'(j_q);
        tag1_q.row <= mmsr_pkg::POS_W'(run_row_q);
        if (state_q == ST_RUN) begin
          if (kk_last) begin
            kk_q <= '0;
            j_q <= j_q + IDX_W'(1);
            if (j_last) begin
              state_q <= ST_IDLE;
            end
          end else begin
            kk_q <= kk_q + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_weight) begin
      w_mem[w_row][w_col] <= element_value_i;
    end
    if (adv) begin
      b_q <= w_mem[kk_q][j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_stream) begin
      row_mem[col_pos_q] <= element_value_i;
    end
    if (adv) begin
      a_q <= row_mem[kk_q];
    end
  end

  mmsr_mac #(
    .DATA_BITS(DATA_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .a_i          ($signed(a_q)),
    .b_i          ($signed(b_q)),
    .tag_i        (tag1_q),
    .adv_o        (adv),
    .busy_o       (mac_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dot_value_o  (dot_value_o),
    .result_row_o (result_row_o),
    .result_col_o (result_col_o),
    .row_done_o   (row_done_o),
    .matrix_done_o(matrix_done_o)
  );

endmodule
